/* design/timestamp_sort_range_query_defines.svh */
// Assertion macros shared by the checker of the sorted time-stamp store.
// Depends on nothing; include with the bare file name.
`ifndef TIMESTAMP_SORT_RANGE_QUERY_DEFINES_SVH
`define TIMESTAMP_SORT_RANGE_QUERY_DEFINES_SVH

// A property checked at every rising edge outside reset.
`define TSRQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsrq check failed");

// A valid request that is stalled stays valid with the same payload.
`define TSRQ_ASSERT_HOLD(lbl, clk, rst_n, vld, stl, pay) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) \
    (vld && stl) |=> (vld && $stable(pay))) \
    else $error("tsrq stalled request changed");

`endif

/* design/tsrq_pkg.sv */
// Types and constants of the sorted time-stamp store with date-range query.
// Used by the cell, the top level and the checker; depends on nothing.
package tsrq_pkg;

  localparam int unsigned DefaultDepth = 64;
  localparam int unsigned KeyW         = 26;
  localparam int unsigned AddrW        = 48;
  localparam int unsigned DateW        = 9;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_LOAD,
    CMD_ROTATE,
    CMD_CLEAR
  } cell_cmd_e;

  typedef struct packed {
    op_e         operation;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [31:0] ip_address;
    logic [15:0] port;
    logic [3:0]  end_month;
    logic [4:0]  end_day;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [31:0] out_ip_address;
    logic [15:0] out_port;
    logic        last;
    logic        none_found;
  } out_req_t;

  typedef struct packed {
    logic             valid;
    logic [KeyW-1:0]  key;
    logic [AddrW-1:0] addr;
  } entry_t;

  typedef struct packed {
    cell_cmd_e        cmd;
    logic [KeyW-1:0]  new_key;
    logic [AddrW-1:0] new_addr;
  } cell_ctrl_t;

endpackage

/* design/tsrq_cell.sv */
// One storage cell of the sorted insertion chain.
// Depends on tsrq_pkg for the entry and control types.
module tsrq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tsrq_pkg::cell_ctrl_t ctrl_i,
  input  tsrq_pkg::entry_t    prev_i,
  input  logic                prev_move_i,
  input  tsrq_pkg::entry_t    next_i,
  output tsrq_pkg::entry_t    entry_o,
  output logic                move_o
);

  logic                       valid_q, valid_d;
  logic [tsrq_pkg::KeyW-1:0]  key_q, key_d;
  logic [tsrq_pkg::AddrW-1:0] addr_q, addr_d;

  assign move_o  = !valid_q || (key_q > ctrl_i.new_key);
  assign entry_o = '{valid: valid_q, key: key_q, addr: addr_q};

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    addr_d  = addr_q;
    unique case (ctrl_i.cmd)
      tsrq_pkg::CMD_LOAD: begin
        if (move_o) begin
          if (prev_move_i) begin
            valid_d = prev_i.valid;
            key_d   = prev_i.key;
            addr_d  = prev_i.addr;
          end else begin
            valid_d = 1'b1;
            key_d   = ctrl_i.new_key;
            addr_d  = ctrl_i.new_addr;
          end
        end
      end
      tsrq_pkg::CMD_ROTATE: begin
        valid_d = next_i.valid;
        key_d   = next_i.key;
        addr_d  = next_i.addr;
      end
      tsrq_pkg::CMD_CLEAR: begin
        valid_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    addr_q <= addr_d;
  end

endmodule

/* design/timestamp_sort_range_query.sv */
// Load and clear requests are taken one per cycle, back to back, while no query runs.
// A query stalls input while the chain rotates once, and also while out_stall_i holds
// the result register. A match waits in a holding register for the next match, or for
// the end of the scan if it is the last, and then moves to the result register.
// Reset empties the store and drops any query; keys and addresses stay.
module timestamp_sort_range_query #(
  parameter int unsigned DEPTH = tsrq_pkg::DefaultDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  tsrq_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output tsrq_pkg::out_req_t out_req_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                      state_q;
  logic [CntW-1:0]             cnt_q;
  logic [tsrq_pkg::DateW-1:0]  lo_q, hi_q;
  tsrq_pkg::entry_t            pend_q;
  logic                        out_valid_q;
  tsrq_pkg::out_req_t          out_req_q;

  tsrq_pkg::cell_ctrl_t        ctrl;
  tsrq_pkg::entry_t            entry_w [DEPTH];
  logic                        move_w  [DEPTH];

  logic                        in_fire, out_free, cnt_done, full, hit;
  logic [tsrq_pkg::DateW-1:0]  head_date;

  function automatic tsrq_pkg::out_req_t to_out(tsrq_pkg::entry_t e, logic last);
    tsrq_pkg::out_req_t r;
    r.out_month      = e.key[25:22];
    r.out_day        = e.key[21:17];
    r.out_hour       = e.key[16:12];
    r.out_minute     = e.key[11:6];
    r.out_second     = e.key[5:0];
    r.out_ip_address = e.addr[47:16];
    r.out_port       = e.addr[15:0];
    r.last           = last;
    r.none_found     = 1'b0;
    return r;
  endfunction

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cnt_done    = (cnt_q == CntW'(DEPTH));
  assign full        = entry_w[DEPTH-1].valid;
  assign head_date   = entry_w[0].key[tsrq_pkg::KeyW-1 -: tsrq_pkg::DateW];
  assign hit         = entry_w[0].valid && (head_date >= lo_q) && (head_date <= hi_q);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  always_comb begin
    ctrl.cmd      = tsrq_pkg::CMD_HOLD;
    ctrl.new_key  = {in_req_i.month, in_req_i.day, in_req_i.hour,
                     in_req_i.minute, in_req_i.second};
    ctrl.new_addr = {in_req_i.ip_address, in_req_i.port};
    if (in_fire) begin
      case (in_req_i.operation)
        tsrq_pkg::OP_LOAD:  ctrl.cmd = full ? tsrq_pkg::CMD_HOLD : tsrq_pkg::CMD_LOAD;
        tsrq_pkg::OP_CLEAR: ctrl.cmd = tsrq_pkg::CMD_CLEAR;
        default:            ctrl.cmd = tsrq_pkg::CMD_HOLD;
      endcase
    end else if (state_q == ST_SCAN && out_free && !cnt_done) begin
      ctrl.cmd = tsrq_pkg::CMD_ROTATE;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      tsrq_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .prev_i      ('0),
        .prev_move_i (1'b0),
        .next_i      (entry_w[(i + 1) % DEPTH]),
        .entry_o     (entry_w[i]),
        .move_o      (move_w[i])
      );
    end else begin : g_body
      tsrq_cell u_cell (
        .clk_i       (clk_i),
        .rst_ni      (rst_ni),
        .ctrl_i      (ctrl),
        .prev_i      (entry_w[i-1]),
        .prev_move_i (move_w[i-1]),
        .next_i      (entry_w[(i + 1) % DEPTH]),
        .entry_o     (entry_w[i]),
        .move_o      (move_w[i])
      );
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_req_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (out_valid_q && !out_stall_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_fire && in_req_i.operation == tsrq_pkg::OP_QUERY) begin
            lo_q         <= {in_req_i.month, in_req_i.day};
            hi_q         <= {in_req_i.end_month, in_req_i.end_day};
            cnt_q        <= '0;
            pend_q.valid <= 1'b0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (out_free) begin
            if (!cnt_done) begin
              cnt_q <= cnt_q + 1'b1;
              if (hit) begin
                pend_q <= entry_w[0];
              end
              if (hit && pend_q.valid) begin
                out_valid_q <= 1'b1;
                out_req_q   <= to_out(pend_q, 1'b0);
              end else begin
                out_valid_q <= 1'b0;
              end
            end else begin
              out_valid_q <= 1'b1;
              if (pend_q.valid) begin
                out_req_q <= to_out(pend_q, 1'b1);
              end else begin
                out_req_q <= '{last: 1'b1, none_found: 1'b1, default: '0};
              end
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/tsrq_checker.sv */
// Port-level checks of the sorted time-stamp store, bound to the top level.
// Depends on tsrq_pkg and timestamp_sort_range_query_defines.svh.
`include "timestamp_sort_range_query_defines.svh"

module tsrq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input tsrq_pkg::in_req_t  in_req_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input tsrq_pkg::out_req_t out_req_o
);

  `TSRQ_ASSERT_HOLD(a_out_hold, clk_i, rst_ni, out_valid_o, out_stall_i, out_req_o)
  `TSRQ_ASSERT(a_none_last, clk_i, rst_ni, (out_valid_o && out_req_o.none_found) |-> out_req_o.last)
  `TSRQ_ASSERT(a_none_zero, clk_i, rst_ni, (out_valid_o && out_req_o.none_found) |-> (out_req_o.out_ip_address == '0 && out_req_o.out_port == '0 && out_req_o.out_month == '0))
  `TSRQ_ASSERT(a_mid_busy, clk_i, rst_ni, (out_valid_o && !out_req_o.last) |-> in_stall_o)
  `TSRQ_ASSERT(a_query_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o && in_req_i.operation == tsrq_pkg::OP_QUERY) |=> in_stall_o)

endmodule

bind timestamp_sort_range_query tsrq_checker u_tsrq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

/* test/timestamp_sort_range_query_check.sv */
// Checker for the sorted time-stamp store: watches both request channels, keeps a sorted
// copy of the stored records and compares every result with the predicted one.
// Depends on tsrq_pkg for the request types and widths.
module timestamp_sort_range_query_check
  import tsrq_pkg::*;
#(
  parameter int unsigned DEPTH = DefaultDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  in_req_t  in_req_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  out_req_t out_req_i,
  output int       fail_count_o,
  output int       pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxReports = 10;

  logic [KeyW-1:0]  sorted_keys  [DEPTH];
  logic [AddrW-1:0] sorted_addrs [DEPTH];
  int unsigned      record_total = 0;
  out_req_t         matches_q [$];

  function automatic void add_result(input out_req_t r);
    matches_q.insert(matches_q.size(), r);
  endfunction

  function automatic void insert_record(input in_req_t req);
    logic [KeyW-1:0] key;
    int unsigned slot;
    key = {req.month, req.day, req.hour, req.minute, req.second};
    if (record_total >= DEPTH) return;
    slot = 0;
    while (slot < record_total && sorted_keys[slot] <= key) slot++;
    for (int unsigned i = record_total; i > slot; i--) begin
      sorted_keys[i]  = sorted_keys[i-1];
      sorted_addrs[i] = sorted_addrs[i-1];
    end
    sorted_keys[slot]  = key;
    sorted_addrs[slot] = {req.ip_address, req.port};
    record_total++;
  endfunction

  function automatic void search_dates(input in_req_t req);
    logic [DateW-1:0] first_date;
    logic [DateW-1:0] last_date;
    logic [DateW-1:0] date;
    out_req_t hit;
    int final_hit;
    first_date = {req.month, req.day};
    last_date  = {req.end_month, req.end_day};
    final_hit  = -1;
    for (int i = 0; i < int'(record_total); i++) begin
      date = sorted_keys[i][KeyW-1 -: DateW];
      if (date >= first_date && date <= last_date) final_hit = i;
    end
    if (final_hit < 0) begin
      hit = '0;
      hit.last = 1'b1;
      hit.none_found = 1'b1;
      add_result(hit);
      return;
    end
    for (int i = 0; i <= final_hit; i++) begin
      date = sorted_keys[i][KeyW-1 -: DateW];
      if (date >= first_date && date <= last_date) begin
        hit = '0;
        {hit.out_month, hit.out_day, hit.out_hour, hit.out_minute, hit.out_second} =
          sorted_keys[i];
        {hit.out_ip_address, hit.out_port} = sorted_addrs[i];
        hit.last = (i == final_hit);
        add_result(hit);
      end
    end
  endfunction

  function automatic string describe(input out_req_t r);
    return $sformatf("%0d/%0d %0d:%0d:%0d ip %h port %0d last %b none_found %b",
                     r.out_month, r.out_day, r.out_hour, r.out_minute, r.out_second,
                     r.out_ip_address, r.out_port, r.last, r.none_found);
  endfunction

  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        case (in_req_i.operation)
          OP_LOAD: begin
            insert_record(in_req_i);
          end
          OP_QUERY: begin
            search_dates(in_req_i);
          end
          OP_CLEAR: begin
            record_total = 0;
          end
          default: begin
          end
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (matches_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= MaxReports) begin
            $display("Unexpected result: %s", describe(out_req_i));
          end
        end else begin
          want = matches_q.pop_front();
          if (out_req_i !== want) begin
            fail_count_o++;
            if (fail_count_o <= MaxReports) begin
              $display("Result mismatch: expected %s, got %s",
                       describe(want), describe(out_req_i));
            end
          end
        end
      end
    end
    pending_o = matches_q.size();
  end

endmodule

/* test/timestamp_sort_range_query_test.sv */
// Testbench top for the sorted time-stamp store: drives loads, date-range queries, clears and
// the unused operation code with random idling and result stalls. Depends on tsrq_pkg, the block and its checker.
module timestamp_sort_range_query_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tsrq_pkg::*;

  localparam int unsigned Depth       = DefaultDepth;
  localparam logic [1:0]  OpIgnored   = 2'd3;
  localparam int unsigned TotalItems  = 230;
  localparam int unsigned CalmItems   = 30;
  localparam int unsigned QuietLimit  = 4000;

  logic     clk_i;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_req    = '0;
  logic     in_stall;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_req_t out_req;
  int       fail_count;
  int       pending;

  int unsigned sent       = 0;
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned stall_left = 0;
  int unsigned quiet      = 0;
  in_req_t     prev_load  = '0;

  timestamp_sort_range_query #(
    .DEPTH(Depth)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_req_o  (out_req)
  );

  timestamp_sort_range_query_check #(
    .DEPTH(Depth)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_req_i    (in_req),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_req_i   (out_req),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(13, 0);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("timestamp_sort_range_query_test NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic in_req_t any_fields();
    in_req_t r;
    r.operation  = OP_LOAD;
    r.month      = 4'($urandom);
    r.day        = 5'($urandom);
    r.hour       = 5'($urandom);
    r.minute     = 6'($urandom);
    r.second     = 6'($urandom);
    r.ip_address = $urandom;
    r.port       = 16'($urandom);
    r.end_month  = 4'($urandom);
    r.end_day    = 5'($urandom);
    return r;
  endfunction

  function automatic in_req_t load_at(input logic [3:0] m, input logic [4:0] d,
                                      input logic [4:0] h, input logic [5:0] mi,
                                      input logic [5:0] s);
    in_req_t r = any_fields();
    r.operation = OP_LOAD;
    {r.month, r.day, r.hour, r.minute, r.second} = {m, d, h, mi, s};
    return r;
  endfunction

  function automatic in_req_t date_query(input logic [3:0] m, input logic [4:0] d,
                                         input logic [3:0] em, input logic [4:0] ed);
    in_req_t r = any_fields();
    r.operation = OP_QUERY;
    {r.month, r.day, r.end_month, r.end_day} = {m, d, em, ed};
    return r;
  endfunction

  // Dense loads crowd a few dates so that equal keys and long match lists are common.
  function automatic in_req_t load_req(input bit dense);
    in_req_t r = any_fields();
    r.operation = OP_LOAD;
    if ($urandom_range(99) < 20) begin
      {r.month, r.day, r.hour, r.minute, r.second} =
        {prev_load.month, prev_load.day, prev_load.hour, prev_load.minute, prev_load.second};
    end else if ($urandom_range(99) < 88) begin
      r.month  = 4'($urandom_range(dense ? 3 : 12, 1));
      r.day    = 5'($urandom_range(dense ? 4 : 31, 1));
      r.hour   = 5'($urandom_range(dense ? 1 : 23, 0));
      r.minute = 6'($urandom_range(dense ? 1 : 59, 0));
      r.second = 6'($urandom_range(dense ? 1 : 59, 0));
    end
    prev_load = r;
    return r;
  endfunction

  function automatic in_req_t query_req();
    in_req_t r = any_fields();
    int unsigned pick = $urandom_range(99);
    r.operation = OP_QUERY;
    if (pick < 60) begin
      r.month     = 4'($urandom_range(12, 1));
      r.end_month = 4'($urandom_range(12, r.month));
      r.day       = 5'($urandom_range(31, 1));
      r.end_day   = 5'($urandom_range(31, 1));
    end else if (pick < 75) begin
      {r.month, r.day, r.end_month, r.end_day} = {4'd1, 5'd1, 4'd12, 5'd31};
    end else if (pick < 85) begin
      r.month     = 4'($urandom_range(12, 2));
      r.end_month = 4'($urandom_range(r.month - 1, 1));
    end
    return r;
  endfunction

  task automatic send(input in_req_t req);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= req;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    if (req.operation != op_e'(OpIgnored)) sent++;
  endtask

  task automatic send_bare(input op_e op);
    in_req_t r;
    r = any_fields();
    r.operation = op;
    send(r);
  endtask

  initial begin
    in_req_t     req;
    int unsigned pick;
    repeat (12) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    send(date_query(4'd1, 5'd1, 4'd12, 5'd31));
    req = load_at(4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    req.ip_address = '1;
    req.port = '1;
    send(req);
    req = load_at(4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    req.ip_address = '0;
    req.port = '0;
    send(req);
    send(load_at(4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send(load_at(4'd1, 5'd1, 5'd0, 6'd0, 6'd0));
    send(load_at(4'd15, 5'd31, 5'd31, 6'd63, 6'd63));
    send(load_at(4'd0, 5'd0, 5'd0, 6'd0, 6'd0));
    send(load_at(4'd6, 5'd15, 5'd12, 6'd30, 6'd30));
    send(load_at(4'd6, 5'd15, 5'd12, 6'd30, 6'd29));
    send(date_query(4'd1, 5'd1, 4'd12, 5'd31));
    send(date_query(4'd0, 5'd0, 4'd15, 5'd31));
    send(date_query(4'd12, 5'd31, 4'd1, 5'd1));
    send(date_query(4'd6, 5'd15, 4'd6, 5'd15));
    send(date_query(4'd2, 5'd1, 4'd5, 5'd31));
    send_bare(op_e'(OpIgnored));
    send(date_query(4'd0, 5'd0, 4'd15, 5'd31));
    send_bare(OP_CLEAR);
    send(date_query(4'd0, 5'd0, 4'd15, 5'd31));

    // Overfill the store so the last loads are dropped, then read it all back.
    idle_pct = 30;
    stall_pct = 15;
    repeat (Depth + 2) send(load_req(1'b1));
    send(date_query(4'd0, 5'd0, 4'd15, 5'd31));
    send(query_req());
    send_bare(OP_CLEAR);

    while (sent < TotalItems) begin
      if (sent >= TotalItems - CalmItems) begin
        idle_pct = 0;
        stall_pct = 0;
      end else if (sent % 40 == 0) begin
        idle_pct = $urandom_range(2) * 20;
        stall_pct = $urandom_range(2) * 10;
      end
      pick = $urandom_range(99);
      if (pick < 58) begin
        send(load_req($urandom_range(1) == 1));
      end else if (pick < 88) begin
        send(query_req());
      end else if (pick < 94) begin
        send_bare(OP_CLEAR);
      end else begin
        send_bare(op_e'(OpIgnored));
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (Depth + 20) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("timestamp_sort_range_query_test OK");
    end else begin
      $display("timestamp_sort_range_query_test NOT OK");
    end
    $finish;
  end

endmodule
